// ----- rtl/lmbs_pkg.sv -----
// ============================================================================
// lmbs_pkg: shared types and constants of the bit-plane scanner
// input kinds, register indexes, row actions, queue entry and result types
// ============================================================================
package lmbs_pkg;

   // input kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_PLANE0_TICKS  = 2'd0;
   localparam logic [1:0] CSR_PLANE1_TICKS  = 2'd1;
   localparam logic [1:0] CSR_PLANE2_TICKS  = 2'd2;
   localparam logic [1:0] CSR_FIRST_COMPARE = 2'd3;

   // register reset values
   localparam logic [7:0] PLANE0_TICKS_RESET  = 8'd2;
   localparam logic [7:0] PLANE1_TICKS_RESET  = 8'd5;
   localparam logic [7:0] PLANE2_TICKS_RESET  = 8'd22;
   localparam logic [7:0] FIRST_COMPARE_RESET = 8'd20;

   // row actions
   localparam logic [1:0] ACT_NONE        = 2'd0;
   localparam logic [1:0] ACT_SHIFT       = 2'd1;
   localparam logic [1:0] ACT_LOAD_FIRST  = 2'd2;
   localparam logic [1:0] ACT_LOAD_SECOND = 2'd3;

   // row at which the second row register is loaded
   localparam logic [3:0] SECOND_REG_ROW = 4'd8;

   // queue depth and fill level width
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_REPORT,
      OP_WRITE,
      OP_LATCH,
      OP_BLANK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       byte_sel;
      logic [1:0] action;
      logic       wrap;
      logic       fired;
   } op_meta_type;

   typedef struct packed {
      logic [7:0] col_low;
      logic [7:0] col_high;
      logic [1:0] row_action;
      logic       frame_wrap;
      logic       scan_fired;
   } rsp_type;

endpackage

// ----- rtl/lmbs_fifo.sv -----
// ============================================================================
// lmbs_fifo: small register queue
// first-word fall-through queue with fill level
// ============================================================================
module lmbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign empty    = (level_ff == '0);
   assign full     = (level_ff == LVL_W'(DEPTH));
   assign level    = level_ff;
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lmbs_front.sv -----
// ============================================================================
// lmbs_front: scan sequencer
// tick counting, plane and row stepping, register file, frame write decode
// ============================================================================
module lmbs_front #(
   parameter int PLANE_COUNT   = 3,
   parameter int ROW_COUNT     = 16,
   parameter int BYTES_PER_ROW = 2,
   parameter int ADDR_W        = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            kind,
   input  logic [1:0]            plane_sel,
   input  logic [3:0]            row_sel,
   input  logic                  byte_sel,
   input  logic [7:0]            pixel_byte,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output lmbs_pkg::op_meta_type op_meta,
   output logic [ADDR_W-1:0]     op_addr
);

   logic [7:0] tick_ff, tick_in;
   logic [7:0] compare_ff, compare_in;
   logic [1:0] plane_ff, plane_in;
   logic [3:0] row_ff, row_in;
   logic       halted_ff, halted_in;
   logic [7:0] p0_ticks_ff, p0_ticks_in;
   logic [7:0] p1_ticks_ff, p1_ticks_in;
   logic [7:0] p2_ticks_ff, p2_ticks_in;

   logic [2:0] plane_inc;
   logic [4:0] row_inc;
   logic       plane_wrap, row_wrap;
   logic [1:0] plane_step;
   logic [3:0] row_step;
   logic [1:0] step_action;
   logic [7:0] step_ticks;
   logic       in_range;
   logic [1:0] addr_plane;
   logic [3:0] addr_row;

   // candidate scan step
   always_comb begin
      plane_inc  = {1'b0, plane_ff} + 3'd1;
      plane_wrap = (plane_inc >= 3'(PLANE_COUNT));
      plane_step = plane_wrap ? 2'd0 : plane_inc[1:0];
      row_inc    = {1'b0, row_ff} + 5'd1;
      row_wrap   = (row_inc >= 5'(ROW_COUNT));
      if (plane_wrap) begin
         row_step = row_wrap ? 4'd0 : row_inc[3:0];
      end else begin
         row_step = row_ff;
      end
      if (!plane_wrap) begin
         step_action = lmbs_pkg::ACT_NONE;
      end else if (row_step == 4'd0) begin
         step_action = lmbs_pkg::ACT_LOAD_FIRST;
      end else if (row_step == lmbs_pkg::SECOND_REG_ROW) begin
         step_action = lmbs_pkg::ACT_LOAD_SECOND;
      end else begin
         step_action = lmbs_pkg::ACT_SHIFT;
      end
      case (plane_step)
         2'd0:    step_ticks = p0_ticks_ff;
         2'd1:    step_ticks = p1_ticks_ff;
         default: step_ticks = p2_ticks_ff;
      endcase
      in_range = ({1'b0, plane_sel} < 3'(PLANE_COUNT)) &&
                 ({1'b0, row_sel} < 5'(ROW_COUNT)) &&
                 ({1'b0, byte_sel} < 2'(BYTES_PER_ROW));
   end

   always_comb begin
      tick_in     = tick_ff;
      compare_in  = compare_ff;
      plane_in    = plane_ff;
      row_in      = row_ff;
      halted_in   = halted_ff;
      p0_ticks_in = p0_ticks_ff;
      p1_ticks_in = p1_ticks_ff;
      p2_ticks_in = p2_ticks_ff;

      op_meta.op       = lmbs_pkg::OP_REPORT;
      op_meta.data     = pixel_byte;
      op_meta.byte_sel = byte_sel;
      op_meta.action   = lmbs_pkg::ACT_NONE;
      op_meta.wrap     = 1'b0;
      op_meta.fired    = 1'b0;
      addr_plane       = plane_sel;
      addr_row         = row_sel;

      case (kind)
         lmbs_pkg::KIND_TICK: begin
            if (!halted_ff) begin
               if (tick_ff == compare_ff) begin
                  tick_in        = 8'd0;
                  plane_in       = plane_step;
                  row_in         = row_step;
                  compare_in     = step_ticks;
                  op_meta.op     = lmbs_pkg::OP_LATCH;
                  op_meta.action = step_action;
                  op_meta.wrap   = plane_wrap && row_wrap;
                  op_meta.fired  = 1'b1;
                  addr_plane     = plane_step;
                  addr_row       = row_step;
               end else begin
                  tick_in = tick_ff + 8'd1;
               end
            end
         end
         lmbs_pkg::KIND_WRITE: begin
            if (in_range) begin
               op_meta.op = lmbs_pkg::OP_WRITE;
            end
         end
         lmbs_pkg::KIND_STOP: begin
            halted_in  = 1'b1;
            op_meta.op = lmbs_pkg::OP_BLANK;
         end
         default: begin
         end
      endcase

      if (!accept) begin
         tick_in    = tick_ff;
         compare_in = compare_ff;
         plane_in   = plane_ff;
         row_in     = row_ff;
         halted_in  = halted_ff;
      end

      if (csr_we) begin
         case (csr_index)
            lmbs_pkg::CSR_PLANE0_TICKS:  p0_ticks_in = csr_wdata;
            lmbs_pkg::CSR_PLANE1_TICKS:  p1_ticks_in = csr_wdata;
            lmbs_pkg::CSR_PLANE2_TICKS:  p2_ticks_in = csr_wdata;
            lmbs_pkg::CSR_FIRST_COMPARE: compare_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign op_addr = ADDR_W'(int'(addr_plane) * ROW_COUNT + int'(addr_row));

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= 8'd0;
         compare_ff  <= lmbs_pkg::FIRST_COMPARE_RESET;
         plane_ff    <= 2'd0;
         row_ff      <= 4'd0;
         halted_ff   <= 1'b0;
         p0_ticks_ff <= lmbs_pkg::PLANE0_TICKS_RESET;
         p1_ticks_ff <= lmbs_pkg::PLANE1_TICKS_RESET;
         p2_ticks_ff <= lmbs_pkg::PLANE2_TICKS_RESET;
      end else begin
         tick_ff     <= tick_in;
         compare_ff  <= compare_in;
         plane_ff    <= plane_in;
         row_ff      <= row_in;
         halted_ff   <= halted_in;
         p0_ticks_ff <= p0_ticks_in;
         p1_ticks_ff <= p1_ticks_in;
         p2_ticks_ff <= p2_ticks_in;
      end
   end

endmodule

// ----- rtl/lmbs_back.sv -----
// ============================================================================
// lmbs_back: frame store and column drive
// executes queued writes and latches, builds one result per entry
// ============================================================================
module lmbs_back #(
   parameter int BYTES_PER_ROW = 2,
   parameter int ENTRY_COUNT   = 48,
   parameter int ADDR_W        = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  lmbs_pkg::op_meta_type          op_meta,
   input  logic [ADDR_W-1:0]              op_addr,
   input  logic [lmbs_pkg::LEVEL_W-1:0]   out_level,
   output logic                           op_pop,
   output logic                           rsp_push,
   output lmbs_pkg::rsp_type              rsp
);

   localparam int PEND_W = lmbs_pkg::LEVEL_W + 1;

   logic [PEND_W-1:0]     pending;
   logic                  issue;
   logic                  stage_v_ff;
   lmbs_pkg::op_meta_type stage_meta_ff;
   logic [15:0]           col_ff, col_in;
   logic [7:0]            lane_byte [BYTES_PER_ROW];
   logic [7:0]            high_byte;

   // credit: results in the output queue plus the one in flight
   assign pending = {1'b0, out_level} + PEND_W'(stage_v_ff);
   assign issue   = op_valid && (pending < PEND_W'(lmbs_pkg::QUEUE_DEPTH));
   assign op_pop  = issue;

   for (genvar b = 0; b < BYTES_PER_ROW; b++) begin : g_bank
      logic [7:0]             mem_ff [ENTRY_COUNT];
      logic [ENTRY_COUNT-1:0] valid_ff;
      logic [7:0]             rd_ff;
      logic                   rd_valid_ff;
      logic                   wr_hit;

      assign wr_hit = issue && (op_meta.op == lmbs_pkg::OP_WRITE) &&
                      (op_meta.byte_sel == 1'(b));

      always_ff @(posedge clock) begin
         if (wr_hit) begin
            mem_ff[op_addr] <= op_meta.data;
         end
         if (issue && (op_meta.op == lmbs_pkg::OP_LATCH)) begin
            rd_ff       <= mem_ff[op_addr];
            rd_valid_ff <= valid_ff[op_addr];
         end
      end

      // never written entries read as blank
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= '0;
         end else if (wr_hit) begin
            valid_ff[op_addr] <= 1'b1;
         end
      end

      assign lane_byte[b] = rd_valid_ff ? rd_ff : 8'd0;
   end

   assign high_byte = (BYTES_PER_ROW > 1) ? lane_byte[BYTES_PER_ROW-1] : 8'd0;

   always_comb begin
      col_in = col_ff;
      if (stage_v_ff) begin
         case (stage_meta_ff.op)
            lmbs_pkg::OP_LATCH: col_in = {high_byte, lane_byte[0]};
            lmbs_pkg::OP_BLANK: col_in = 16'd0;
            default: begin
            end
         endcase
      end
   end

   assign rsp_push       = stage_v_ff;
   assign rsp.col_low    = col_in[7:0];
   assign rsp.col_high   = col_in[15:8];
   assign rsp.row_action = stage_meta_ff.action;
   assign rsp.frame_wrap = stage_meta_ff.wrap;
   assign rsp.scan_fired = stage_meta_ff.fired;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
         col_ff     <= 16'd0;
      end else begin
         stage_v_ff <= issue;
         col_ff     <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         stage_meta_ff <= op_meta;
      end
   end

endmodule

// ----- rtl/led_matrix_bitplane_scanner.sv -----
// ============================================================================
// led_matrix_bitplane_scanner: multiplexed LED matrix scanner, bit-plane drive
// tick-driven row and plane sequencer with a byte-wide frame store
// ============================================================================
// usage
//   input queue: req_push with req_kind (tick, frame byte write, stop) and
//   the write fields; a transfer happens when req_push is high and req_full
//   is low. every transfer yields exactly one result, in order.
//   result queue: while rsp_empty is low the oldest result sits on the rsp_
//   ports; rsp_pop takes it. each result carries the column drive after the
//   item, the row action, the frame wrap kick and the scan step flag.
//   configuration: csr_we writes csr_wdata into register csr_index
//   (plane tick counts, first compare); the user writes only while idle, the block itself does not enforce this.
// timing
//   one item per cycle sustained while the result queue drains. the
//   sequencer updates at the transfer edge; the item then waits in the
//   work queue, the store is accessed and the result queue is written,
//   after which the result is poppable. the single read port of the frame store sets that path.
// reset and stall
//   synchronous reset clears the sequencer and the store valid bits at
//   once, so the display is blank straight away; no clearing pass.
//   if rsp_pop stays low the result queue fills, the store stage stops,
//   the work queue fills and req_full rises; nothing is lost.
// ============================================================================
module led_matrix_bitplane_scanner #(
   parameter int PLANE_COUNT   = 3,
   parameter int ROW_COUNT     = 16,
   parameter int BYTES_PER_ROW = 2
) (
   input  logic       clock,
   input  logic       reset,
   // input queue
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_plane_sel,
   input  logic [3:0] req_row_sel,
   input  logic       req_byte_sel,
   input  logic [7:0] req_pixel_byte,
   // result queue
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_col_low,
   output logic [7:0] rsp_col_high,
   output logic [1:0] rsp_row_action,
   output logic       rsp_frame_wrap,
   output logic       rsp_scan_fired,
   // configuration
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // one store entry per plane and row, one bank per column byte
   localparam int ENTRY_COUNT = PLANE_COUNT * ROW_COUNT;
   localparam int ADDR_W      = $clog2(ENTRY_COUNT);
   localparam int META_W      = $bits(lmbs_pkg::op_meta_type);
   localparam int WORK_W      = META_W + ADDR_W;
   localparam int RSP_W       = $bits(lmbs_pkg::rsp_type);

   logic                         req_accept;
   lmbs_pkg::op_meta_type        front_meta;
   logic [ADDR_W-1:0]            front_addr;

   logic [WORK_W-1:0]            work_head;
   logic                         work_empty;
   logic [lmbs_pkg::LEVEL_W-1:0] work_level;
   lmbs_pkg::op_meta_type        back_meta;
   logic [ADDR_W-1:0]            back_addr;
   logic                         back_pop;

   logic                         out_push;
   lmbs_pkg::rsp_type            out_data;
   logic [RSP_W-1:0]             out_head;
   logic                         out_full;
   logic [lmbs_pkg::LEVEL_W-1:0] out_level;
   lmbs_pkg::rsp_type            rsp_head;

   assign req_accept = req_push && !req_full;

   // sequencer: classifies each transfer into store work
   lmbs_front #(
      .PLANE_COUNT   (PLANE_COUNT),
      .ROW_COUNT     (ROW_COUNT),
      .BYTES_PER_ROW (BYTES_PER_ROW),
      .ADDR_W        (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .kind       (req_kind),
      .plane_sel  (req_plane_sel),
      .row_sel    (req_row_sel),
      .byte_sel   (req_byte_sel),
      .pixel_byte (req_pixel_byte),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .op_meta    (front_meta),
      .op_addr    (front_addr)
   );

   // work queue between sequencer and store
   lmbs_fifo #(
      .WIDTH (WORK_W),
      .DEPTH (lmbs_pkg::QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data ({front_meta, front_addr}),
      .pop       (back_pop),
      .pop_data  (work_head),
      .empty     (work_empty),
      .full      (req_full),
      .level     (work_level)
   );

   assign back_meta = lmbs_pkg::op_meta_type'(work_head[WORK_W-1:ADDR_W]);
   assign back_addr = work_head[ADDR_W-1:0];

   // frame store and column drive
   lmbs_back #(
      .BYTES_PER_ROW (BYTES_PER_ROW),
      .ENTRY_COUNT   (ENTRY_COUNT),
      .ADDR_W        (ADDR_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!work_empty),
      .op_meta   (back_meta),
      .op_addr   (back_addr),
      .out_level (out_level),
      .op_pop    (back_pop),
      .rsp_push  (out_push),
      .rsp       (out_data)
   );

   // result queue
   lmbs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (lmbs_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (rsp_empty),
      .full      (out_full),
      .level     (out_level)
   );

   assign rsp_head       = lmbs_pkg::rsp_type'(out_head);
   assign rsp_col_low    = rsp_head.col_low;
   assign rsp_col_high   = rsp_head.col_high;
   assign rsp_row_action = rsp_head.row_action;
   assign rsp_frame_wrap = rsp_head.frame_wrap;
   assign rsp_scan_fired = rsp_head.scan_fired;

   // the credit check must keep the result queue from overflowing
   a_rsp_no_overflow: assert property (
      @(posedge clock) disable iff (reset) out_push |-> !out_full
   ) else $error("result queue written while full");

   // a transfer that is not popped at once leaves the work queue non-empty
   a_work_level: assert property (
      @(posedge clock) disable iff (reset)
      (req_accept && !back_pop) |=> (work_level != '0)
   ) else $error("work queue level lost a transfer");

   // no scan step means no row action and no frame kick
   a_idle_fields: assert property (
      @(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_scan_fired) |->
      (rsp_row_action == lmbs_pkg::ACT_NONE && !rsp_frame_wrap)
   ) else $error("row action or wrap without a scan step");

   // the frame kick always comes with the first register load
   a_wrap_loads_first: assert property (
      @(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_wrap) |-> (rsp_row_action == lmbs_pkg::ACT_LOAD_FIRST)
   ) else $error("frame wrap without first register load");

endmodule
